// ===== rtl/fvds_pkg.sv =====
// Shared types and constants for the fog volume density sampler.
// No dependencies; every other file imports this package.
`default_nettype none

package fvds_pkg;

  // Default sample coordinate width (signed, 8 fraction bits)
  localparam int COORD_BITS_DEF = 20;
  // Width of each packed centre / inverse size field
  localparam int PACK_BITS      = 20;

  // Configuration port
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 64;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SHAPE_MODE    = 4'd0,
    REG_CENTER        = 4'd1,
    REG_INV_HALF_SIZE = 4'd2,
    REG_EDGE_FALLOFF  = 4'd3,
    REG_NOISE_AMOUNT  = 4'd4,
    REG_NOISE_SCALE   = 4'd5,
    REG_NOISE_SEED    = 4'd6,
    REG_EXT_BASE      = 4'd7
  } cfg_reg_t;

  // Shape codes (anything else is a box)
  localparam logic [1:0] SHAPE_SPHERE = 2'd1;
  localparam logic [1:0] SHAPE_CYL    = 2'd2;

  // Fixed-point constants
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [17:0] THREE_Q16 = 18'd196608;
  localparam logic [16:0] VAR_BASE  = 17'd11796;
  localparam logic [16:0] VAR_GAIN  = 17'd86508;
  localparam logic [23:0] RES_MAX   = 24'hFF_FFFF;

  // Corner hash multipliers
  localparam logic [31:0] HASH_KX   = 32'h8da6b343;
  localparam logic [31:0] HASH_KY   = 32'hd8163841;
  localparam logic [31:0] HASH_KZ   = 32'hcb1ab31f;
  localparam logic [31:0] HASH_KS   = 32'h165667b1;
  localparam logic [31:0] HASH_KMIX = 32'h7feb352d;

  // Pipeline map: stage numbers 1..NSTG, register of stage k loads on en[k]
  localparam int NSTG        = 17;
  localparam int STG_HASH    = 2;   // first hash stage (four stages)
  localparam int STG_SQRT    = 5;   // first square root stage
  localparam int SQRT_STAGES = 4;
  localparam int SQRT_STEPS  = 4;   // result bits per stage
  localparam int STG_DIV     = 10;  // first divider stage
  localparam int DIV_STAGES  = 4;
  localparam int DIV_STEPS   = 4;   // quotient bits per stage

endpackage

`default_nettype wire

// ===== rtl/fvds_if.sv =====
// Handshake channel interfaces: sample input, result output, register writes.
// Depends on fvds_pkg.
`default_nettype none

interface fvds_in_if import fvds_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] world_x;
  logic signed [COORD_BITS-1:0] world_y;
  logic signed [COORD_BITS-1:0] world_z;

  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface fvds_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] extinction_value;

  modport source (output valid, extinction_value, input ready);
  modport sink   (input valid, extinction_value, output ready);
endinterface

interface fvds_cfg_if import fvds_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/fvds_hash.sv =====
// Four-stage corner hash for the eight lattice corners of a noise cell.
// Depends on fvds_pkg; stage enables come from the top level.
`default_nettype none

module fvds_hash import fvds_pkg::*; (
  input  logic            clk,
  input  logic [NSTG:1]   en,
  input  logic [31:0]     cell_x,
  input  logic [31:0]     cell_y,
  input  logic [31:0]     cell_z,
  input  logic [31:0]     seed,
  output logic [23:0]     corner [8]
);

  logic [31:0] hx_r, hy_r, hz_r, hs_r;
  logic [31:0] mix_nxt [8];
  logic [31:0] mix_r   [8];
  logic [31:0] mul_r   [8];
  logic [31:0] fin_nxt [8];

  // Stage 1: per-axis products (the +1 corner adds the constant)
  always_ff @(posedge clk) begin
    if (en[STG_HASH]) begin
      hx_r <= cell_x * HASH_KX;
      hy_r <= cell_y * HASH_KY;
      hz_r <= cell_z * HASH_KZ;
      hs_r <= seed * HASH_KS;
    end
  end

  // Stage 2: combine axes per corner, first xor-shift
  always_comb begin
    logic [31:0] a;
    for (int i = 0; i < 8; i++) begin
      a = (((i & 1) != 0) ? hx_r + HASH_KX : hx_r)
        ^ (((i & 2) != 0) ? hy_r + HASH_KY : hy_r)
        ^ (((i & 4) != 0) ? hz_r + HASH_KZ : hz_r)
        ^ hs_r;
      mix_nxt[i] = a ^ (a >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_HASH+1]) begin
      for (int i = 0; i < 8; i++) mix_r[i] <= mix_nxt[i];
    end
  end

  // Stage 3: mixing multiply
  always_ff @(posedge clk) begin
    if (en[STG_HASH+2]) begin
      for (int i = 0; i < 8; i++) mul_r[i] <= mix_r[i] * HASH_KMIX;
    end
  end

  // Stage 4: final xor-shift, keep 24 bits
  always_comb begin
    for (int i = 0; i < 8; i++) fin_nxt[i] = mul_r[i] ^ (mul_r[i] >> 15);
  end

  always_ff @(posedge clk) begin
    if (en[STG_HASH+3]) begin
      for (int i = 0; i < 8; i++) corner[i] <= fin_nxt[i][23:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fvds_sqrt.sv =====
// Pipelined floor square root of a 32-bit value, four result bits per stage.
// Depends on fvds_pkg; stage enables come from the top level.
`default_nettype none

module fvds_sqrt import fvds_pkg::*; (
  input  logic          clk,
  input  logic [NSTG:1] en,
  input  logic [31:0]   radicand,
  output logic [15:0]   root
);

  logic [32:0] n_in  [SQRT_STAGES];
  logic [32:0] r_in  [SQRT_STAGES];
  logic [32:0] n_nxt [SQRT_STAGES];
  logic [32:0] r_nxt [SQRT_STAGES];
  logic [32:0] n_r   [SQRT_STAGES];
  logic [32:0] r_r   [SQRT_STAGES];

  // Stage inputs: first from the radicand, the rest from the previous stage
  always_comb begin
    n_in[0] = {1'b0, radicand};
    r_in[0] = '0;
    for (int g = 1; g < SQRT_STAGES; g++) begin
      n_in[g] = n_r[g-1];
      r_in[g] = r_r[g-1];
    end
  end

  // Digit-by-digit root, trial bit falls by two places per step
  always_comb begin
    logic [32:0] bitv;
    logic [32:0] n, r;
    for (int g = 0; g < SQRT_STAGES; g++) begin
      n = n_in[g];
      r = r_in[g];
      for (int j = 0; j < SQRT_STEPS; j++) begin
        bitv = 33'(1) << (30 - 2 * (SQRT_STEPS * g + j));
        if (n >= r + bitv) begin
          n = n - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
      end
      n_nxt[g] = n;
      r_nxt[g] = r;
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < SQRT_STAGES; g++) begin
      if (en[STG_SQRT+g]) begin
        n_r[g] <= n_nxt[g];
        r_r[g] <= r_nxt[g];
      end
    end
  end

  assign root = r_r[SQRT_STAGES-1][15:0];

endmodule

`default_nettype wire

// ===== rtl/fvds_div.sv =====
// Pipelined restoring divider for the edge ramp: (num << 16) / den, num < den.
// Depends on fvds_pkg; stage enables come from the top level.
`default_nettype none

module fvds_div import fvds_pkg::*; (
  input  logic          clk,
  input  logic [NSTG:1] en,
  input  logic [16:0]   num,
  input  logic [16:0]   den,
  output logic [15:0]   quot
);

  logic [17:0] rem_in  [DIV_STAGES];
  logic [15:0] q_in    [DIV_STAGES];
  logic [17:0] rem_nxt [DIV_STAGES];
  logic [15:0] q_nxt   [DIV_STAGES];
  logic [17:0] rem_r   [DIV_STAGES];
  logic [15:0] q_r     [DIV_STAGES];

  always_comb begin
    rem_in[0] = {1'b0, num};
    q_in[0]   = '0;
    for (int g = 1; g < DIV_STAGES; g++) begin
      rem_in[g] = rem_r[g-1];
      q_in[g]   = q_r[g-1];
    end
  end

  // One quotient bit per step: shift, trial subtract
  always_comb begin
    logic [17:0] rm;
    logic [15:0] q;
    for (int g = 0; g < DIV_STAGES; g++) begin
      rm = rem_in[g];
      q  = q_in[g];
      for (int j = 0; j < DIV_STEPS; j++) begin
        rm = {rm[16:0], 1'b0};
        if (rm >= {1'b0, den}) begin
          rm = rm - {1'b0, den};
          q  = {q[14:0], 1'b1};
        end else begin
          q  = {q[14:0], 1'b0};
        end
      end
      rem_nxt[g] = rm;
      q_nxt[g]   = q;
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < DIV_STAGES; g++) begin
      if (en[STG_DIV+g]) begin
        rem_r[g] <= rem_nxt[g];
        q_r[g]   <= q_nxt[g];
      end
    end
  end

  assign quot = q_r[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/fog_volume_density_sampler.sv =====
// Fog volume density sampler: 17-stage pipeline, one transaction per cycle while
// out_ch is ready; back-pressure stalls only stages holding data, and bubbles
// close up. Depth is set by the root and the edge-ramp divider (four stages each,
// four bits per stage) and the hash chain.
// Reset (synchronous, rst_n low) clears all stage valid bits and loads register
// defaults. Depends on fvds_pkg, fvds_if, fvds_hash, fvds_sqrt, fvds_div.
`default_nettype none

module fog_volume_density_sampler import fvds_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fvds_in_if.sink     in_ch,
  fvds_out_if.source  out_ch,
  fvds_cfg_if.sink    cfg_ch
);

  localparam int DW = ((COORD_BITS > PACK_BITS) ? COORD_BITS : PACK_BITS) + 1;
  localparam int PW = DW + PACK_BITS;
  localparam int NW = COORD_BITS + 17;

  typedef struct packed {
    logic        outside;
    logic [15:0] rbox;
    logic [15:0] py;
  } side_t;

  typedef struct packed {
    logic        outside;
    logic        edge_on;
    logic [16:0] dens;
  } tail_t;

  // ---------------- configuration registers ----------------
  logic [1:0]             shape_r;
  logic [3*PACK_BITS-1:0] center_r;
  logic [3*PACK_BITS-1:0] inv_r;
  logic [16:0]            falloff_r;
  logic [16:0]            amount_r;
  logic [15:0]            scale_r;
  logic [31:0]            seed_r;
  logic [15:0]            base_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r   <= '0;
      center_r  <= '0;
      inv_r     <= '0;
      falloff_r <= '0;
      amount_r  <= '0;
      scale_r   <= 16'd256;
      seed_r    <= '0;
      base_r    <= 16'd256;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_SHAPE_MODE:    shape_r   <= cfg_ch.data[1:0];
        REG_CENTER:        center_r  <= cfg_ch.data[3*PACK_BITS-1:0];
        REG_INV_HALF_SIZE: inv_r     <= cfg_ch.data[3*PACK_BITS-1:0];
        REG_EDGE_FALLOFF:  falloff_r <= cfg_ch.data[16:0];
        REG_NOISE_AMOUNT:  amount_r  <= cfg_ch.data[16:0];
        REG_NOISE_SCALE:   scale_r   <= cfg_ch.data[15:0];
        REG_NOISE_SEED:    seed_r    <= cfg_ch.data[31:0];
        REG_EXT_BASE:      base_r    <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // Saturated / corrected register views
  logic [16:0] ef_sat, amt_sat;
  logic [15:0] sc_eff;
  logic        is_sph, is_cyl;
  assign ef_sat  = (falloff_r > ONE_Q16) ? ONE_Q16 : falloff_r;
  assign amt_sat = (amount_r > ONE_Q16) ? ONE_Q16 : amount_r;
  assign sc_eff  = (scale_r == '0) ? 16'd1 : scale_r;
  assign is_sph  = (shape_r == SHAPE_SPHERE);
  assign is_cyl  = (shape_r == SHAPE_CYL);

  // ---------------- pipeline control ----------------
  logic [NSTG:1] en;
  logic [NSTG:1] v_r;

  // A stage loads when empty or when the stage after it moves on
  always_comb begin
    en[NSTG] = !v_r[NSTG] || out_ch.ready;
    for (int k = NSTG - 1; k >= 1; k--) en[k] = !v_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_ch.valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_ch.ready = en[1];

  // ---------------- stage 1: offset, magnitude, noise position ----------------
  logic signed [COORD_BITS-1:0] wv  [3];
  logic signed [PACK_BITS-1:0]  cen [3];
  logic [PACK_BITS-1:0]         inv [3];
  logic signed [DW-1:0]         dlt [3];
  logic [DW-1:0]                ad  [3];
  logic signed [NW-1:0]         np  [3];
  logic [DW-1:0]                ad_r  [3];
  logic signed [NW-1:0]         npos_r[3];

  assign wv[0] = in_ch.world_x;
  assign wv[1] = in_ch.world_y;
  assign wv[2] = in_ch.world_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cen[i] = $signed(center_r[PACK_BITS*i +: PACK_BITS]);
      inv[i] = inv_r[PACK_BITS*i +: PACK_BITS];
      dlt[i] = DW'(wv[i]) - DW'(cen[i]);
      ad[i]  = dlt[i][DW-1] ? DW'(-dlt[i]) : DW'(dlt[i]);
      np[i]  = NW'(wv[i]) * NW'($signed({1'b0, sc_eff}));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        ad_r[i]   <= ad[i];
        npos_r[i] <= np[i];
      end
    end
  end

  // Lattice cell (floor, wrapped to 32 bits) and fraction
  logic signed [63:0] np64 [3];
  logic [31:0]        lat_cell [3];
  logic [15:0]        frac [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      np64[i]     = 64'(npos_r[i]);
      lat_cell[i] = np64[i][47:16];
      frac[i]     = npos_r[i][15:0];
    end
  end

  // ---------------- stage 2: scale to local, fraction squared ----------------
  logic [PW-1:0] pf [3];
  logic          out2_r;
  logic [15:0]   p_r   [3];
  logic [15:0]   t2_r  [3];
  logic [15:0]   fr2_r [3];
  logic [31:0]   ff    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pf[i] = PW'(ad_r[i]) * PW'(inv[i]);
      ff[i] = 32'(frac[i]) * 32'(frac[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      out2_r <= (|pf[0][PW-1:20]) || (|pf[1][PW-1:20]) || (|pf[2][PW-1:20]);
      for (int i = 0; i < 3; i++) begin
        p_r[i]   <= pf[i][19:4];
        t2_r[i]  <= ff[i][31:16];
        fr2_r[i] <= frac[i];
      end
    end
  end

  // ---------------- stage 3: squares, box radius, smoothstep weights ----------------
  logic [31:0] sq3_r [3];
  logic [15:0] rbox3, rbox3_r, py3_r;
  logic        out3_r;
  logic [33:0] wp   [3];
  logic [16:0] w3_r [3];

  always_comb begin
    rbox3 = p_r[0];
    if (p_r[1] > rbox3) rbox3 = p_r[1];
    if (p_r[2] > rbox3) rbox3 = p_r[2];
    for (int i = 0; i < 3; i++)
      wp[i] = 34'(t2_r[i]) * 34'(THREE_Q16 - {1'b0, fr2_r[i], 1'b0});
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      out3_r  <= out2_r;
      rbox3_r <= rbox3;
      py3_r   <= p_r[1];
      for (int i = 0; i < 3; i++) begin
        sq3_r[i] <= 32'(p_r[i]) * 32'(p_r[i]);
        w3_r[i]  <= wp[i][32:16];
      end
    end
  end

  // ---------------- stage 4: sum of squares ----------------
  logic [33:0] sum4;
  logic [31:0] sum4_r;
  side_t       side_r [4:8];
  logic [16:0] wgt_r  [4:7][3];

  assign sum4 = 34'(sq3_r[0]) + 34'(sq3_r[2]) + (is_sph ? 34'(sq3_r[1]) : 34'd0);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sum4_r          <= sum4[31:0];
      side_r[4].outside <= out3_r || ((is_sph || is_cyl) && (|sum4[33:32]));
      side_r[4].rbox  <= rbox3_r;
      side_r[4].py    <= py3_r;
      for (int i = 0; i < 3; i++) wgt_r[4][i] <= w3_r[i];
    end
    // Side data travels on through stages 5..8, weights through stages 5..7
    for (int k = 5; k <= 8; k++) begin
      if (en[k]) side_r[k] <= side_r[k-1];
    end
    for (int k = 5; k <= 7; k++) begin
      if (en[k]) wgt_r[k] <= wgt_r[k-1];
    end
  end

  // ---------------- stages 5..8: root; hash result and trilinear mix ----------------
  logic [15:0] root;
  logic [23:0] corner [8];
  logic [23:0] m_r [4];
  logic [23:0] n_r [2];
  logic [23:0] noise_r;

  fvds_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sum4_r),
    .root     (root)
  );

  fvds_hash u_hash (
    .clk    (clk),
    .en     (en),
    .cell_x (lat_cell[0]),
    .cell_y (lat_cell[1]),
    .cell_z (lat_cell[2]),
    .seed   (seed_r),
    .corner (corner)
  );

  // a + (b - a) * w / 2^16, floor
  function automatic logic [23:0] lerp24(logic [23:0] a, logic [23:0] b, logic [16:0] w);
    logic signed [24:0] df;
    logic signed [42:0] pr;
    logic signed [42:0] s;
    df = $signed({1'b0, b}) - $signed({1'b0, a});
    pr = 43'(df) * 43'($signed({1'b0, w}));
    s  = $signed({19'd0, a}) + (pr >>> 16);
    return s[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 4; i++) m_r[i] <= lerp24(corner[2*i], corner[2*i+1], wgt_r[5][0]);
    end
    if (en[7]) begin
      n_r[0] <= lerp24(m_r[0], m_r[1], wgt_r[6][1]);
      n_r[1] <= lerp24(m_r[2], m_r[3], wgt_r[6][1]);
    end
    if (en[8]) noise_r <= lerp24(n_r[0], n_r[1], wgt_r[7][2]);
  end

  // ---------------- stage 9: radius, edge ramp start, variation ----------------
  logic [15:0] r9;
  logic [16:0] thr9;
  logic [40:0] vp9;
  logic        out9_r, edge9_r;
  logic [16:0] num9_r, var9_r;

  always_comb begin
    if (is_sph) begin
      r9 = root;
    end else if (is_cyl) begin
      r9 = (side_r[8].py > root) ? side_r[8].py : root;
    end else begin
      r9 = side_r[8].rbox;
    end
    thr9 = ONE_Q16 - ef_sat;
    vp9  = 41'(VAR_GAIN) * 41'(noise_r);
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      out9_r  <= side_r[8].outside;
      edge9_r <= (ef_sat != '0) && ({1'b0, r9} > thr9);
      num9_r  <= {1'b0, r9} - thr9;
      var9_r  <= VAR_BASE + vp9[40:24];
    end
  end

  // ---------------- stage 10: density blend; divider stages 10..13 ----------------
  logic signed [17:0] dv10;
  logic signed [35:0] dp10;
  logic signed [35:0] ds10;
  tail_t              tail_r [10:16];
  logic [15:0]        quot;

  always_comb begin
    dv10 = $signed({1'b0, var9_r}) - $signed({1'b0, ONE_Q16});
    dp10 = 36'(dv10) * 36'($signed({1'b0, amt_sat}));
    ds10 = 36'(ONE_Q16) + (dp10 >>> 16);
  end

  fvds_div u_div (
    .clk  (clk),
    .en   (en),
    .num  (num9_r),
    .den  (ef_sat),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (en[10]) begin
      tail_r[10].outside <= out9_r;
      tail_r[10].edge_on <= edge9_r;
      tail_r[10].dens    <= ds10[16:0];
    end
    for (int k = 11; k <= 16; k++) begin
      if (en[k]) tail_r[k] <= tail_r[k-1];
    end
  end

  // ---------------- stages 14..15: smoothstep of the ramp, coverage ----------------
  logic [31:0] qq14;
  logic [15:0] q14_r, t2q14_r;
  logic [33:0] sp15;
  logic [16:0] cov15_r;

  assign qq14 = 32'(quot) * 32'(quot);
  assign sp15 = 34'(t2q14_r) * 34'(THREE_Q16 - {1'b0, q14_r, 1'b0});

  always_ff @(posedge clk) begin
    if (en[14]) begin
      q14_r   <= quot;
      t2q14_r <= qq14[31:16];
    end
    if (en[15]) cov15_r <= tail_r[14].edge_on ? ONE_Q16 - sp15[32:16] : ONE_Q16;
  end

  // ---------------- stages 16..17: scale by base and density, saturate ----------------
  logic [32:0] bc16_r;
  logic [49:0] full17;
  logic [23:0] out_res_r;

  assign full17 = 50'(bc16_r) * 50'(tail_r[16].dens);

  always_ff @(posedge clk) begin
    if (en[16]) bc16_r <= 33'(base_r) * 33'(cov15_r);
    if (en[17]) begin
      if (tail_r[16].outside) begin
        out_res_r <= '0;
      end else if (|full17[49:48]) begin
        out_res_r <= RES_MAX;
      end else begin
        out_res_r <= full17[47:24];
      end
    end
  end

  assign out_ch.valid            = v_r[NSTG];
  assign out_ch.extinction_value = out_res_r;

  // ---------------- assertions ----------------
  a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> v_r[1])
    else $error("input held off with empty first stage");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (en[NSTG] && v_r[NSTG-1] && tail_r[NSTG-1].outside) |=> (out_res_r == '0))
    else $error("sample outside volume gave nonzero extinction");

  a_cov_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[15] |-> (cov15_r <= ONE_Q16))
    else $error("coverage above one");

endmodule

`default_nettype wire
